[sv/w64cl_pkg.sv]
// Types, constants and GUID tables shared by the Wave64 fmt chunk locator.
`default_nettype none

package w64cl_pkg;

  typedef enum logic [2:0] {
    PH_RIFF_GUID  = 3'd0,
    PH_RIFF_SIZE  = 3'd1,
    PH_WAVE_GUID  = 3'd2,
    PH_CHUNK_GUID = 3'd3,
    PH_CHUNK_SIZE = 3'd4,
    PH_SKIP       = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ST_FOUND       = 3'd0,
    ST_BAD_RIFF    = 3'd1,
    ST_BAD_WAVE    = 3'd2,
    ST_SHORT_CHUNK = 3'd3,
    ST_STREAM_END  = 3'd4
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [63:0] payload_offset;
    logic [63:0] payload_len;
  } result_t;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 136;

  // Chunk header: 16-byte GUID plus 64-bit size.
  localparam logic [63:0] HdrBytes  = 64'd24;
  localparam logic [63:0] AlignMask = 64'd7;

  localparam logic [7:0] GuidRiff [16] = '{
    8'h72, 8'h69, 8'h66, 8'h66, 8'h2E, 8'h91, 8'hCF, 8'h11,
    8'hA5, 8'hD6, 8'h28, 8'hDB, 8'h04, 8'hC1, 8'h00, 8'h00
  };
  localparam logic [7:0] GuidWave [16] = '{
    8'h77, 8'h61, 8'h76, 8'h65, 8'hF3, 8'hAC, 8'hD3, 8'h11,
    8'h8C, 8'hD1, 8'h00, 8'hC0, 8'h4F, 8'h8E, 8'hDB, 8'h8A
  };
  localparam logic [7:0] GuidFmt [16] = '{
    8'h66, 8'h6D, 8'h74, 8'h20, 8'hF3, 8'hAC, 8'hD3, 8'h11,
    8'h8C, 8'hD1, 8'h00, 8'hC0, 8'h4F, 8'h8E, 8'hDB, 8'h8A
  };

  function automatic logic [7:0] guid_byte(phase_e ph, logic [3:0] idx);
    logic [7:0] val;
    case (ph)
      PH_RIFF_GUID: val = GuidRiff[idx];
      PH_WAVE_GUID: val = GuidWave[idx];
      default:      val = GuidFmt[idx];
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[sv/w64cl_parser.sv]
// Byte-at-a-time Wave64 header and chunk walker with its parse state.
`default_nettype none

module w64cl_parser
  import w64cl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       start_of_file_i,
  input  wire logic       end_of_file_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  phase_e      phase_q, phase_d, phase_c;
  logic [4:0]  cnt_q, cnt_d, cnt_c;
  logic        match_q, match_d, match_c;
  logic [63:0] acc_q, acc_d, acc_c;
  logic [63:0] off_q, off_d, off_c;
  logic [63:0] cstart_q, cstart_d, cstart_c;
  logic [63:0] skip_q, skip_d, skip_c;
  logic        resolved_q, resolved_d, resolved_c;

  logic [3:0]  idx;
  logic [2:0]  idx3;
  logic        byte_match;
  logic [63:0] size_full;
  logic [63:0] skip_len;
  logic        have_status;

  always_comb begin
    // A start-of-file beat restarts the parse before its own byte is taken.
    phase_c    = start_of_file_i ? PH_RIFF_GUID : phase_q;
    cnt_c      = start_of_file_i ? 5'd0 : cnt_q;
    match_c    = start_of_file_i ? 1'b1 : match_q;
    acc_c      = start_of_file_i ? 64'd0 : acc_q;
    off_c      = start_of_file_i ? 64'd0 : off_q;
    cstart_c   = start_of_file_i ? 64'd0 : cstart_q;
    skip_c     = start_of_file_i ? 64'd0 : skip_q;
    resolved_c = start_of_file_i ? 1'b0 : resolved_q;

    phase_d    = phase_c;
    cnt_d      = cnt_c;
    match_d    = match_c;
    acc_d      = acc_c;
    off_d      = off_c;
    cstart_d   = cstart_c;
    skip_d     = skip_c;
    resolved_d = resolved_c;

    idx        = cnt_c[3:0];
    idx3       = cnt_c[2:0];
    byte_match = (data_byte_i == guid_byte(phase_c, idx));
    size_full  = acc_c | ({56'd0, data_byte_i} << {idx3, 3'b000});
    skip_len   = ((size_full + AlignMask) & ~AlignMask) - HdrBytes;

    have_status         = 1'b0;
    res_o.status        = ST_STREAM_END;
    res_o.payload_offset = 64'd0;
    res_o.payload_len    = 64'd0;

    if (!resolved_c) begin
      case (phase_c)
        PH_RIFF_GUID, PH_WAVE_GUID, PH_CHUNK_GUID: begin
          if (phase_c == PH_CHUNK_GUID && idx == 4'd0) begin
            cstart_d = off_c;
          end
          match_d = match_c & byte_match;
          cnt_d   = {1'b0, idx} + 5'd1;
          if (idx == 4'd15) begin
            cnt_d = 5'd0;
            if (phase_c == PH_RIFF_GUID) begin
              if (!match_d) begin
                have_status  = 1'b1;
                res_o.status = ST_BAD_RIFF;
              end else begin
                phase_d = PH_RIFF_SIZE;
              end
              match_d = 1'b1;
            end else if (phase_c == PH_WAVE_GUID) begin
              if (!match_d) begin
                have_status  = 1'b1;
                res_o.status = ST_BAD_WAVE;
              end else begin
                phase_d = PH_CHUNK_GUID;
              end
              match_d = 1'b1;
            end else begin
              // The match flag is carried into the size field.
              phase_d = PH_CHUNK_SIZE;
              acc_d   = 64'd0;
            end
          end
        end
        PH_RIFF_SIZE: begin
          cnt_d = {2'b00, idx3} + 5'd1;
          if (idx3 == 3'd7) begin
            cnt_d   = 5'd0;
            phase_d = PH_WAVE_GUID;
            match_d = 1'b1;
          end
        end
        PH_CHUNK_SIZE: begin
          acc_d = size_full;
          cnt_d = {2'b00, idx3} + 5'd1;
          if (idx3 == 3'd7) begin
            cnt_d = 5'd0;
            acc_d = 64'd0;
            // A short size is an error even when the GUID is fmt.
            if (size_full < HdrBytes) begin
              have_status  = 1'b1;
              res_o.status = ST_SHORT_CHUNK;
            end else if (match_c) begin
              have_status          = 1'b1;
              res_o.status         = ST_FOUND;
              res_o.payload_offset = cstart_c + HdrBytes;
              res_o.payload_len    = size_full - HdrBytes;
            end else begin
              skip_d  = skip_len;
              phase_d = (skip_len == 64'd0) ? PH_CHUNK_GUID : PH_SKIP;
            end
            match_d = 1'b1;
          end
        end
        PH_SKIP: begin
          skip_d = skip_c - 64'd1;
          if (skip_d == 64'd0) begin
            phase_d = PH_CHUNK_GUID;
          end
        end
        default: begin
        end
      endcase

      off_d = off_c + 64'd1;

      // A result completed by the last byte takes precedence over end of stream.
      if (!have_status && end_of_file_i) begin
        have_status  = 1'b1;
        res_o.status = ST_STREAM_END;
      end
      if (have_status) begin
        resolved_d = 1'b1;
      end
    end

    res_valid_o = fire_i & have_status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_RIFF_GUID;
      cnt_q      <= 5'd0;
      match_q    <= 1'b1;
      acc_q      <= 64'd0;
      off_q      <= 64'd0;
      cstart_q   <= 64'd0;
      skip_q     <= 64'd0;
      resolved_q <= 1'b0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      match_q    <= match_d;
      acc_q      <= acc_d;
      off_q      <= off_d;
      cstart_q   <= cstart_d;
      skip_q     <= skip_d;
      resolved_q <= resolved_d;
    end
  end

  a_result_resolves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> resolved_q)
    else $error("parser not marked resolved after a result");

  a_quiet_when_resolved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && resolved_q && !start_of_file_i) |-> !res_valid_o)
    else $error("second result within one file");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != ST_FOUND) |->
      (res_o.payload_offset == 64'd0 && res_o.payload_len == 64'd0))
    else $error("error result carries nonzero payload fields");

endmodule

`default_nettype wire

[sv/w64cl_out_reg.sv]
// Result register that holds one finished result until the sink takes it.
`default_nettype none

module w64cl_out_reg
  import w64cl_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         ready_o,
  output logic         valid_o,
  input  wire logic    take_i,
  output result_t      res_o
);

  logic    valid_q;
  result_t res_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

[sv/wave64_fmt_chunk_locator.sv]
// Top level of the Wave64 fmt chunk locator: input register, parser, result register.
`default_nettype none

// Takes a Wave64 file as one byte per beat and gives one result per file: the
// offset and size of the fmt payload, or an error code (bad RIFF GUID, bad WAVE
// GUID, chunk size under 24, stream ended). Mark the first byte of a file with
// tuser and the last with tlast; bytes after a file's result are dropped until
// the next start. One byte is taken every cycle unless a full block stalls it; a
// beat lands in the input register, is parsed from there once the result register is
// ready, and a result it completes is registered before the output shows it. A stalled
// sink backs up into tready only once the input and result registers are both full.

module wave64_fmt_chunk_locator
  import w64cl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  output logic                     s_tready_o,
  input  wire logic [InDataW-1:0]  s_tdata_i,   // [7:0] data_byte
  input  wire logic                s_tuser_i,   // [0] start_of_file
  input  wire logic                s_tlast_i,   // end_of_file
  output logic                     m_tvalid_o,
  input  wire logic                m_tready_i,
  output logic [OutDataW-1:0]      m_tdata_o    // [2:0] status, [66:3] payload_offset,
                                                // [130:67] payload_len, [135:131] zero
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_sof_q;
  logic       in_eof_q;

  logic       out_ready;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign advance    = in_valid_q && out_ready;
  assign s_tready_o = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_byte_q <= s_tdata_i;
      in_sof_q  <= s_tuser_i;
      in_eof_q  <= s_tlast_i;
    end
  end

  w64cl_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (advance),
    .data_byte_i     (in_byte_q),
    .start_of_file_i (in_sof_q),
    .end_of_file_i   (in_eof_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  w64cl_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_o (out_ready),
    .valid_o (m_tvalid_o),
    .take_i  (m_tready_i),
    .res_o   (out_res)
  );

  assign m_tdata_o = {5'd0, out_res.payload_len, out_res.payload_offset, out_res.status};

  a_stalled_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_ready) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("buffered input beat lost while stalled");

  a_result_reaches_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> m_tvalid_o)
    else $error("parser result not presented at the output");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!m_tvalid_o || m_tready_i))
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

[verif/wave64_fmt_chunk_locator_checker.sv]
// Checker for the Wave64 fmt chunk locator: tracks the byte stream, predicts results, compares.
module wave64_fmt_chunk_locator_checker
  import w64cl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [7:0]          s_tdata_i,   // [7:0] data_byte
  input  logic                s_tuser_i,   // [0] start_of_file
  input  logic                s_tlast_i,   // end_of_file
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,   // [2:0] status, [66:3] payload_offset,
                                           // [130:67] payload_len, [135:131] zero
  output int                  errors_o,
  output int                  pending_o,
  output int                  results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ShowLimit = 10;
  localparam logic [63:0] ChunkHdr  = 64'd24;

  localparam logic [7:0] RiffId [16] = '{
    8'h72, 8'h69, 8'h66, 8'h66, 8'h2E, 8'h91, 8'hCF, 8'h11,
    8'hA5, 8'hD6, 8'h28, 8'hDB, 8'h04, 8'hC1, 8'h00, 8'h00
  };
  localparam logic [7:0] WaveId [16] = '{
    8'h77, 8'h61, 8'h76, 8'h65, 8'hF3, 8'hAC, 8'hD3, 8'h11,
    8'h8C, 8'hD1, 8'h00, 8'hC0, 8'h4F, 8'h8E, 8'hDB, 8'h8A
  };
  localparam logic [7:0] FmtId [16] = '{
    8'h66, 8'h6D, 8'h74, 8'h20, 8'hF3, 8'hAC, 8'hD3, 8'h11,
    8'h8C, 8'hD1, 8'h00, 8'hC0, 8'h4F, 8'h8E, 8'hDB, 8'h8A
  };

  // Parser state as the block should hold it.
  phase_e      walk_phase;
  logic [4:0]  field_cnt;
  bit          id_match;
  logic [63:0] size_acc;
  logic [63:0] file_pos;
  logic [63:0] chunk_pos;
  logic [63:0] skip_left;
  bit          file_done;

  result_t located_q [$];
  int      mismatches;

  task automatic restart_file();
    walk_phase = PH_RIFF_GUID;
    field_cnt  = '0;
    id_match   = 1'b1;
    size_acc   = '0;
    file_pos   = '0;
    chunk_pos  = '0;
    skip_left  = '0;
    file_done  = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] octet, input logic sof, input logic eof);
    logic [3:0]  idx;
    logic [2:0]  lane;
    logic [7:0]  want;
    logic [63:0] sz;
    bit          hit;
    result_t     res;
    hit = 1'b0;
    res = '0;
    if (sof) restart_file();
    if (file_done) return;
    idx = field_cnt[3:0];
    case (walk_phase)
      PH_RIFF_GUID, PH_WAVE_GUID, PH_CHUNK_GUID: begin
        if (walk_phase == PH_RIFF_GUID) want = RiffId[idx];
        else if (walk_phase == PH_WAVE_GUID) want = WaveId[idx];
        else want = FmtId[idx];
        if (walk_phase == PH_CHUNK_GUID && idx == 4'd0) chunk_pos = file_pos;
        if (octet != want) id_match = 1'b0;
        field_cnt = 5'(idx) + 5'd1;
        if (field_cnt == 5'd16) begin
          field_cnt = '0;
          if (walk_phase == PH_RIFF_GUID) begin
            if (!id_match) begin
              hit = 1'b1;
              res.status = ST_BAD_RIFF;
            end else begin
              walk_phase = PH_RIFF_SIZE;
            end
            id_match = 1'b1;
          end else if (walk_phase == PH_WAVE_GUID) begin
            if (!id_match) begin
              hit = 1'b1;
              res.status = ST_BAD_WAVE;
            end else begin
              walk_phase = PH_CHUNK_GUID;
            end
            id_match = 1'b1;
          end else begin
            // The GUID verdict is kept until the size is known.
            walk_phase = PH_CHUNK_SIZE;
            size_acc   = '0;
          end
        end
      end
      PH_RIFF_SIZE: begin
        field_cnt = 5'(idx[2:0]) + 5'd1;
        if (field_cnt == 5'd8) begin
          field_cnt  = '0;
          walk_phase = PH_WAVE_GUID;
          id_match   = 1'b1;
        end
      end
      PH_CHUNK_SIZE: begin
        lane = idx[2:0];
        size_acc |= 64'(octet) << (8 * lane);
        field_cnt = 5'(lane) + 5'd1;
        if (field_cnt == 5'd8) begin
          sz        = size_acc;
          field_cnt = '0;
          size_acc  = '0;
          if (sz < ChunkHdr) begin
            hit = 1'b1;
            res.status = ST_SHORT_CHUNK;
          end else if (id_match) begin
            hit = 1'b1;
            res.status         = ST_FOUND;
            res.payload_offset = chunk_pos + ChunkHdr;
            res.payload_len    = sz - ChunkHdr;
          end else begin
            // Round up to 8 bytes; this may wrap for huge sizes.
            skip_left  = ((sz + 64'd7) & ~64'd7) - ChunkHdr;
            walk_phase = (skip_left == '0) ? PH_CHUNK_GUID : PH_SKIP;
          end
          id_match = 1'b1;
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 64'd1;
        if (skip_left == '0) walk_phase = PH_CHUNK_GUID;
      end
      default: ;
    endcase
    file_pos = file_pos + 64'd1;
    if (!hit && eof) begin
      hit = 1'b1;
      res.status = ST_STREAM_END;
    end
    if (hit) begin
      file_done = 1'b1;
      located_q.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want_res;
    result_t got_res;
    if (!rst_ni) begin
      restart_file();
      located_q.delete();
      pending_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) parse_byte(s_tdata_i, s_tuser_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) begin
        got_res.status         = status_e'(m_tdata_i[2:0]);
        got_res.payload_offset = m_tdata_i[66:3];
        got_res.payload_len    = m_tdata_i[130:67];
        results_o++;
        if (located_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ShowLimit)
            $display("%0t: result beat with nothing expected: status %0d offset %h size %h",
                     $realtime, m_tdata_i[2:0], m_tdata_i[66:3], m_tdata_i[130:67]);
        end else begin
          want_res = located_q.pop_front();
          if (got_res !== want_res || m_tdata_i[135:131] !== 5'd0) begin
            mismatches++;
            if (mismatches <= ShowLimit)
              $display("%0t: result mismatch: expected status %0d offset %h size %h, got %s",
                       $realtime, want_res.status, want_res.payload_offset,
                       want_res.payload_len,
                       $sformatf("status %0d offset %h size %h pad %h", m_tdata_i[2:0],
                                 m_tdata_i[66:3], m_tdata_i[130:67], m_tdata_i[135:131]));
          end
        end
      end
      pending_o = located_q.size();
    end
    errors_o = mismatches;
  end

endmodule

[verif/wave64_fmt_chunk_locator_tb.sv]
// Testbench top for the Wave64 fmt chunk locator: clock, reset, byte stimulus and verdict.
module wave64_fmt_chunk_locator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import w64cl_pkg::*;

  localparam int HoldCycles      = 200;
  // Slowest legal quiet stretch is the long output hold; allow it many times over.
  localparam int WatchLimit      = 2000;
  localparam int DrainCycles     = 8;
  localparam int BytesPerPhase   = 60;
  localparam int PressureFiles   = 8;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int errors;
  int pending;
  int results;
  int tx_idle_pct = 22;
  int rx_idle_pct = 73;
  int hold_req    = 0;
  int bytes_sent  = 0;
  int files_sent  = 0;

  logic [7:0] image_q [$];

  always #2 clk_i = ~clk_i;

  wave64_fmt_chunk_locator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .s_tlast_i  (s_tlast),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata)
  );

  wave64_fmt_chunk_locator_checker i_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .s_tlast_i  (s_tlast),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results)
  );

  task automatic add_guid(input logic [7:0] id [16], input int bad_idx);
    for (int i = 0; i < 16; i++)
      image_q.push_back((i == bad_idx) ? id[i] ^ 8'($urandom_range(1, 255)) : id[i]);
  endtask

  task automatic add_u64(input logic [63:0] val);
    for (int i = 0; i < 8; i++) image_q.push_back(val[8*i +: 8]);
  endtask

  // A corrupt index of -1 keeps that GUID intact; other_size 0 picks random sizes.
  task automatic build_image(input int bad_riff, input int bad_wave, input int n_other,
                             input int other_size, input int bad_fmt,
                             input logic [63:0] fmt_size, input int tail);
    int sz;
    image_q.delete();
    add_guid(GuidRiff, bad_riff);
    add_u64({$urandom, $urandom});
    add_guid(GuidWave, bad_wave);
    repeat (n_other) begin
      sz = (other_size != 0) ? other_size : 24 + int'($urandom_range(24));
      if ($urandom_range(1) == 0) add_guid(GuidFmt, int'($urandom_range(15)));
      else repeat (16) image_q.push_back(8'($urandom));
      add_u64(64'(sz));
      repeat (((sz + 7) / 8) * 8 - 24) image_q.push_back(8'($urandom));
    end
    add_guid(GuidFmt, bad_fmt);
    add_u64(fmt_size);
    repeat (tail) image_q.push_back(8'($urandom));
  endtask

  task automatic send_beat(input logic [7:0] octet, input logic sof, input logic eof);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= octet;
    s_tuser  <= sof;
    s_tlast  <= eof;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Sends the first cut bytes of the image, or all of it when cut is 0.
  task automatic send_image(input logic sof, input logic eof, input int cut);
    int n;
    n = (cut == 0 || cut > image_q.size()) ? image_q.size() : cut;
    for (int i = 0; i < n; i++) send_beat(image_q[i], sof && (i == 0), eof && (i == n - 1));
    files_sent++;
  endtask

  // The sender goes quiet first so that no beat is offered twice while waiting.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic random_image();
    int          pick;
    int          bad;
    logic [63:0] fsz;
    pick = $urandom_range(99);
    fsz  = ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'(24 + $urandom_range(300));
    bad  = int'($urandom_range(15));
    if (pick < 55) begin
      build_image(-1, -1, $urandom_range(2), 0, -1, fsz, $urandom_range(3));
      send_image(1'b1, 1'($urandom_range(1)), 0);
    end else if (pick < 63) begin
      build_image(bad, -1, 0, 0, -1, fsz, 0);
      send_image(1'b1, 1'($urandom_range(1)), 16 + $urandom_range(3));
    end else if (pick < 70) begin
      build_image(-1, bad, 0, 0, -1, fsz, 0);
      send_image(1'b1, 1'($urandom_range(1)), 40 + $urandom_range(3));
    end else if (pick < 77) begin
      if ($urandom_range(1) == 0) bad = -1;
      build_image(-1, -1, $urandom_range(1), 0, bad, 64'($urandom_range(23)), 0);
      send_image(1'b1, 1'($urandom_range(1)), 0);
    end else if (pick < 88) begin
      // Cut short; without an end mark the next start of file restarts the parser.
      build_image(-1, -1, $urandom_range(2), 0, -1, fsz, 0);
      send_image(1'b1, $urandom_range(4) != 0, $urandom_range(1, image_q.size() - 1));
    end else begin
      image_q.delete();
      repeat ($urandom_range(1, 40)) image_q.push_back(8'($urandom));
      send_image($urandom_range(3) != 0, 1'b1, 0);
    end
  endtask

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no beat accepted for %0d cycles, %0d results outstanding",
             WatchLimit, pending);
    $display("FAIL wave64_fmt_chunk_locator");
    $finish;
  end

  initial begin
    int base_bytes;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Right after reset, without a start mark; the end mark lands on an ignored tail byte.
    build_image(-1, -1, 0, 0, -1, 64'd40, 3);
    send_image(1'b0, 1'b1, 0);
    // Empty fmt payload behind two chunks; the end mark is on the completing byte.
    build_image(-1, -1, 2, 0, -1, 64'd24, 0);
    send_image(1'b1, 1'b1, 0);
    // Chunks of size 24 (nothing to skip) and 25 (rounded up), then a maximal fmt size.
    build_image(-1, -1, 1, 24, -1, '1, 0);
    send_image(1'b1, 1'b0, 0);
    build_image(-1, -1, 1, 25, -1, 64'd31, 2);
    send_image(1'b1, 1'b0, 0);
    // Bad RIFF GUID at either end of the GUID, bytes after the result are dropped.
    build_image(0, -1, 0, 0, -1, 64'd24, 0);
    send_image(1'b1, 1'b1, 20);
    build_image(15, -1, 0, 0, -1, 64'd24, 0);
    send_image(1'b1, 1'b0, 16);
    // Bad WAVE GUID, once with the end mark on the deciding byte.
    build_image(-1, 7, 0, 0, -1, 64'd24, 0);
    send_image(1'b1, 1'b0, 40);
    build_image(-1, 15, 0, 0, -1, 64'd24, 0);
    send_image(1'b1, 1'b1, 40);
    // Sizes under the header length, on fmt and on another chunk.
    build_image(-1, -1, 0, 0, -1, 64'd23, 0);
    send_image(1'b1, 1'b0, 0);
    build_image(-1, -1, 0, 0, -1, 64'd0, 0);
    send_image(1'b1, 1'b0, 0);
    build_image(-1, -1, 0, 0, 3, 64'd17, 0);
    send_image(1'b1, 1'b0, 0);
    // Non-fmt chunk whose rounded size wraps; the stream ends inside the skip.
    build_image(-1, -1, 0, 0, 0, '1, 12);
    send_image(1'b1, 1'b1, 0);
    // One-byte file, then a cut file with no end mark that the next start restarts.
    build_image(-1, -1, 0, 0, -1, 64'd24, 0);
    send_image(1'b1, 1'b1, 1);
    build_image(-1, -1, 0, 0, -1, 64'd64, 0);
    send_image(1'b1, 1'b0, 60);
    build_image(-1, -1, 0, 0, -1, 64'd64, 0);
    send_image(1'b1, 1'b1, 20);
    image_q.delete();
    repeat (16) image_q.push_back(8'hFF);
    send_image(1'b1, 1'b0, 0);
    image_q.delete();
    repeat (8) image_q.push_back(8'h00);
    send_image(1'b1, 1'b1, 0);

    for (int p = 0; p < 3; p++) begin
      wait_drained();
      tx_idle_pct = (p == 0) ? 22 : (p == 1) ? 73 : 0;
      rx_idle_pct = (p == 0) ? 73 : (p == 1) ? 22 : 0;
      base_bytes = bytes_sent;
      while (bytes_sent - base_bytes < BytesPerPhase)
        random_image();
      if (p == 0) begin
        // Back-to-back short error files against a held output fill the block up.
        wait_drained();
        tx_idle_pct = 0;
        hold_req++;
        repeat (PressureFiles) begin
          build_image(int'($urandom_range(15)), -1, 0, 0, -1, 64'd24, 0);
          send_image(1'b1, 1'b0, 16);
        end
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Run covered %0d files in %0d bytes with %0d results checked, over three idle",
             files_sent, bytes_sent, results);
    $display("mixes and a long output hold: GUID errors, short, huge and wrapping sizes, cut files.");
    if (errors == 0) begin
      $display("PASS wave64_fmt_chunk_locator");
    end else begin
      $display("%0d result errors", errors);
      $display("FAIL wave64_fmt_chunk_locator");
    end
    $finish;
  end

endmodule

[wave64_fmt_chunk_locator.f]
sv/w64cl_pkg.sv
sv/w64cl_parser.sv
sv/w64cl_out_reg.sv
sv/wave64_fmt_chunk_locator.sv
verif/wave64_fmt_chunk_locator_checker.sv
verif/wave64_fmt_chunk_locator_tb.sv
